[sv/gasp_pkg.sv]
package gasp_pkg;

    localparam int MAX_PAGES = 8;
    localparam int ATLAS_MAX = 4096;

    localparam int PAGE_W = $clog2(MAX_PAGES);
    localparam int CNT_W  = $clog2(MAX_PAGES + 1);
    localparam int DIM_W  = 13;
    localparam int ROW_W  = 14;
    localparam int POS_W  = 12;
    localparam int SUM_W  = 15;

    localparam logic [DIM_W-1:0] ATLAS_RESET = DIM_W'(1024);
    localparam logic [DIM_W-1:0] ATLAS_CAP   = DIM_W'(ATLAS_MAX);
    localparam logic [ROW_W-1:0] ROW_LIMIT   = ROW_W'(16383);

    typedef enum logic [1:0] {
        STATUS_PLACED  = 2'd0,
        STATUS_EMPTY   = 2'd1,
        STATUS_NO_ROOM = 2'd2,
        STATUS_CLEARED = 2'd3
    } status_t;

endpackage

[sv/glyph_atlas_shelf_packer.sv]
// Shelf allocator for square glyph atlas pages.
// Input stream (s_*): one beat is a request. s_tuser is the kind (0 place,
// 1 clear all pages); s_tdata carries glyph width and height.
// Result stream (m_*): exactly one beat per request. m_tuser is the status
// (placed, empty glyph, no room, cleared); m_tdata carries page, position and
// the opened-page flag, all zero unless the glyph was placed.
// Config channel (cfg_*): writes atlas_size, always ready; write only while
// the block is idle.
// Sequence: a clear or an empty glyph goes straight to the result. A placement
// tries each open page (column check, shelf move on overflow, row check), then
// width and height for a new page if none fits, then updates pen and shelf. The
// result goes valid in the same cycle that the block is idle to accept again.
// The fit checks run one at a time through a single add-and-compare unit.
// s_tready is high only while idle. The result sits in an output register,
// so the next request is accepted while it waits; a stalled receiver holds
// that beat and a finished second result then waits in the sequencer.
// Reset: no pages open, atlas_size = 1024, no result pending.
module glyph_atlas_shelf_packer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // glyph_width[12:0], glyph_height[25:13], zero fill
    input  logic [0:0]  s_tuser,   // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // page_index[2:0], pos_x[14:3], pos_y[26:15],
                                   // opened_page[27], zero fill
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data   // atlas_size
);

    localparam int PW = gasp_pkg::PAGE_W;
    localparam int CW = gasp_pkg::CNT_W;
    localparam int DW = gasp_pkg::DIM_W;
    localparam int RW = gasp_pkg::ROW_W;
    localparam int XW = gasp_pkg::POS_W;
    localparam int SW = gasp_pkg::SUM_W;
    localparam int NP = gasp_pkg::MAX_PAGES;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COL,
        ST_MOVE,
        ST_ROW,
        ST_CHKW,
        ST_CHKH,
        ST_UPD,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;

    logic [DW-1:0] atlas_size_reg, atlas_size_next;
    logic [CW-1:0] pages_open_reg, pages_open_next;
    logic [PW-1:0] page_reg, page_next;
    logic [DW-1:0] width_reg, width_next;
    logic [DW-1:0] height_reg, height_next;

    gasp_pkg::status_t res_status_reg, res_status_next;
    logic [PW-1:0]     res_page_reg, res_page_next;
    logic [XW-1:0]     res_x_reg, res_x_next;
    logic [XW-1:0]     res_y_reg, res_y_next;
    logic              res_opened_reg, res_opened_next;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [31:0]   m_tdata_reg, m_tdata_next;
    logic [1:0]    m_tuser_reg, m_tuser_next;

    logic [DW-1:0] pen_column_mem [NP];
    logic [RW-1:0] pen_row_mem    [NP];
    logic [DW-1:0] shelf_mem      [NP];

    logic          wr_en;
    logic [PW-1:0] wr_page;
    logic [DW-1:0] wr_column;
    logic [RW-1:0] wr_row;
    logic [DW-1:0] wr_shelf;

    logic [DW-1:0] cur_column;
    logic [RW-1:0] cur_row;
    logic [DW-1:0] cur_shelf;

    logic [DW-1:0] side;
    logic [RW-1:0] op_a;
    logic [DW-1:0] op_b;
    logic [SW-1:0] sum;
    logic          over;

    logic          accept;
    logic          out_free;
    logic [CW-1:0] page_inc;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign side = (atlas_size_reg > gasp_pkg::ATLAS_CAP) ? gasp_pkg::ATLAS_CAP : atlas_size_reg;

    assign cur_column = pen_column_mem[page_reg];
    assign cur_row    = pen_row_mem[page_reg];
    assign cur_shelf  = shelf_mem[page_reg];
    assign page_inc   = CW'(page_reg) + CW'(1);

    // shared add-and-compare unit: a + b + pad against the page side
    always_comb begin
        case (state_reg)
            ST_COL, ST_UPD: begin
                op_a = RW'(cur_column);
                op_b = width_reg;
            end
            ST_MOVE: begin
                op_a = cur_row;
                op_b = cur_shelf;
            end
            ST_ROW: begin
                op_a = cur_row;
                op_b = height_reg;
            end
            ST_CHKW: begin
                op_a = '0;
                op_b = width_reg;
            end
            ST_CHKH: begin
                op_a = '0;
                op_b = height_reg;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign sum  = SW'(op_a) + SW'(op_b) + SW'(1);
    assign over = sum > SW'(side);

    always_comb begin
        state_next      = state_reg;
        atlas_size_next = atlas_size_reg;
        pages_open_next = pages_open_reg;
        page_next       = page_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_opened_next = res_opened_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        wr_en           = 1'b0;
        wr_page         = page_reg;
        wr_column       = cur_column;
        wr_row          = cur_row;
        wr_shelf        = cur_shelf;

        if (cfg_valid) begin
            atlas_size_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    width_next      = s_tdata[12:0];
                    height_next     = s_tdata[25:13];
                    page_next       = '0;
                    res_page_next   = '0;
                    res_x_next      = '0;
                    res_y_next      = '0;
                    res_opened_next = 1'b0;
                    if (s_tuser[0]) begin
                        pages_open_next = '0;
                        res_status_next = gasp_pkg::STATUS_CLEARED;
                        state_next      = ST_RESULT;
                    end else if (s_tdata[12:0] == '0 || s_tdata[25:13] == '0) begin
                        res_status_next = gasp_pkg::STATUS_EMPTY;
                        state_next      = ST_RESULT;
                    end else if (pages_open_reg == '0) begin
                        state_next = ST_CHKW;
                    end else begin
                        state_next = ST_COL;
                    end
                end
            end
            ST_COL: begin
                state_next = over ? ST_MOVE : ST_ROW;
            end
            ST_MOVE: begin
                wr_en      = 1'b1;
                wr_column  = '0;
                wr_shelf   = '0;
                wr_row     = sum[SW-1] ? gasp_pkg::ROW_LIMIT : sum[RW-1:0];
                state_next = ST_ROW;
            end
            ST_ROW: begin
                if (over) begin
                    if (page_inc < pages_open_reg) begin
                        page_next  = page_inc[PW-1:0];
                        state_next = ST_COL;
                    end else begin
                        state_next = ST_CHKW;
                    end
                end else begin
                    res_status_next = gasp_pkg::STATUS_PLACED;
                    res_page_next   = page_reg;
                    res_x_next      = cur_column[XW-1:0];
                    res_y_next      = cur_row[XW-1:0];
                    res_opened_next = 1'b0;
                    state_next      = ST_UPD;
                end
            end
            ST_CHKW: begin
                if (over || pages_open_reg >= CW'(NP)) begin
                    res_status_next = gasp_pkg::STATUS_NO_ROOM;
                    state_next      = ST_RESULT;
                end else begin
                    state_next = ST_CHKH;
                end
            end
            ST_CHKH: begin
                if (over) begin
                    res_status_next = gasp_pkg::STATUS_NO_ROOM;
                    state_next      = ST_RESULT;
                end else begin
                    wr_en           = 1'b1;
                    wr_page         = pages_open_reg[PW-1:0];
                    wr_column       = '0;
                    wr_row          = '0;
                    wr_shelf        = '0;
                    page_next       = pages_open_reg[PW-1:0];
                    pages_open_next = pages_open_reg + CW'(1);
                    res_status_next = gasp_pkg::STATUS_PLACED;
                    res_page_next   = pages_open_reg[PW-1:0];
                    res_x_next      = '0;
                    res_y_next      = '0;
                    res_opened_next = 1'b1;
                    state_next      = ST_UPD;
                end
            end
            ST_UPD: begin
                wr_en      = 1'b1;
                wr_column  = sum[DW-1:0];
                wr_shelf   = (height_reg > cur_shelf) ? height_reg : cur_shelf;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = {4'b0, res_opened_reg, res_y_reg, res_x_reg, res_page_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            atlas_size_reg <= gasp_pkg::ATLAS_RESET;
            pages_open_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            atlas_size_reg <= atlas_size_next;
            pages_open_reg <= pages_open_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        page_reg       <= page_next;
        width_reg      <= width_next;
        height_reg     <= height_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        res_opened_reg <= res_opened_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pen_column_mem[wr_page] <= wr_column;
            pen_row_mem[wr_page]    <= wr_row;
            shelf_mem[wr_page]      <= wr_shelf;
        end
    end

endmodule

[sim/glyph_atlas_shelf_packer_tb.sv]
`timescale 1ns / 100ps

module glyph_atlas_shelf_packer_tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;

    class shelf_scoreboard;
        typedef struct {
            gasp_pkg::status_t           status;
            logic [gasp_pkg::PAGE_W-1:0] page;
            logic [gasp_pkg::POS_W-1:0]  x;
            logic [gasp_pkg::POS_W-1:0]  y;
            logic                        opened;
        } placement_t;

        logic [gasp_pkg::DIM_W-1:0] atlas_size;
        logic [gasp_pkg::CNT_W-1:0] pages_open;
        logic [gasp_pkg::ROW_W-1:0] pen_col [gasp_pkg::MAX_PAGES];
        logic [gasp_pkg::ROW_W-1:0] pen_row [gasp_pkg::MAX_PAGES];
        logic [gasp_pkg::DIM_W-1:0] shelf_h [gasp_pkg::MAX_PAGES];
        placement_t                 placements_due[$];
        int                         errors;
        int                         checked;

        function void reset_state();
            atlas_size = gasp_pkg::ATLAS_RESET;
            pages_open = '0;
            for (int i = 0; i < gasp_pkg::MAX_PAGES; i++) begin
                pen_col[i] = '0;
                pen_row[i] = '0;
                shelf_h[i] = '0;
            end
            placements_due.delete();
            errors = 0;
            checked = 0;
        endfunction

        function void set_atlas(logic [gasp_pkg::DIM_W-1:0] value);
            atlas_size = value;
        endfunction

        function int pending();
            return placements_due.size();
        endfunction

        function void note_request(logic kind, logic [gasp_pkg::DIM_W-1:0] w,
                                   logic [gasp_pkg::DIM_W-1:0] h);
            int         side;
            int         p;
            int         nr;
            placement_t r;
            side = (atlas_size > gasp_pkg::ATLAS_MAX) ? gasp_pkg::ATLAS_MAX
                                                       : int'(atlas_size);
            r.status = gasp_pkg::STATUS_PLACED;
            r.page = '0;
            r.x = '0;
            r.y = '0;
            r.opened = 1'b0;
            if (kind) begin
                pages_open = '0;
                r.status = gasp_pkg::STATUS_CLEARED;
            end else if (w == 0 || h == 0) begin
                r.status = gasp_pkg::STATUS_EMPTY;
            end else begin
                for (p = 0; p < int'(pages_open) && p < gasp_pkg::MAX_PAGES; p++) begin
                    if (int'(pen_col[p]) + int'(w) + 1 > side) begin
                        nr = int'(pen_row[p]) + int'(shelf_h[p]) + 1;
                        pen_col[p] = '0;
                        pen_row[p] = (nr > int'(gasp_pkg::ROW_LIMIT)) ? gasp_pkg::ROW_LIMIT
                                                                      : gasp_pkg::ROW_W'(nr);
                        shelf_h[p] = '0;
                    end
                    if (int'(pen_row[p]) + int'(h) + 1 <= side)
                        break;
                end
                if (p >= int'(pages_open) || p >= gasp_pkg::MAX_PAGES) begin
                    if (int'(pages_open) >= gasp_pkg::MAX_PAGES || int'(w) + 1 > side
                            || int'(h) + 1 > side) begin
                        r.status = gasp_pkg::STATUS_NO_ROOM;
                    end else begin
                        p = int'(pages_open);
                        pages_open = pages_open + 1'b1;
                        pen_col[p] = '0;
                        pen_row[p] = '0;
                        shelf_h[p] = '0;
                        r.opened = 1'b1;
                    end
                end
                if (r.status == gasp_pkg::STATUS_PLACED) begin
                    r.page = p[gasp_pkg::PAGE_W-1:0];
                    r.x = pen_col[p][gasp_pkg::POS_W-1:0];
                    r.y = pen_row[p][gasp_pkg::POS_W-1:0];
                    pen_col[p] = pen_col[p] + w + 1'b1;
                    if (h > shelf_h[p])
                        shelf_h[p] = h;
                end
            end
            placements_due = {placements_due, r};
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at result %0d: %s", checked, msg);
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                report($sformatf("%s got %0d want %0d", name, got, want));
        endtask

        task check_placement(logic [1:0] tuser, logic [31:0] tdata);
            placement_t e;
            checked++;
            if (placements_due.size() == 0) begin
                report("result beat with nothing pending");
                return;
            end
            e = placements_due.pop_front();
            compare_field("status", int'(tuser), int'(e.status));
            compare_field("page_index", int'(tdata[2:0]), int'(e.page));
            compare_field("pos_x", int'(tdata[14:3]), int'(e.x));
            compare_field("pos_y", int'(tdata[26:15]), int'(e.y));
            compare_field("opened_page", int'(tdata[27]), int'(e.opened));
            compare_field("fill", int'(tdata[31:28]), 0);
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [12:0] cfg_data = '0;

    shelf_scoreboard sb;
    bit              quiet = 1'b0;
    bit              hold_req = 1'b0;
    int              cycles = 0;

    glyph_atlas_shelf_packer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic [gasp_pkg::DIM_W-1:0] pick_dim(int side);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return gasp_pkg::DIM_W'($urandom_range(1, side / 8 + 1));
        else if (r < 90)
            return gasp_pkg::DIM_W'($urandom_range(1, side));
        else
            return gasp_pkg::DIM_W'($urandom_range(side, 8191));
    endfunction

    task automatic send_item(logic kind, logic [gasp_pkg::DIM_W-1:0] w,
                             logic [gasp_pkg::DIM_W-1:0] h);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 14);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {6'b0, h, w};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(kind, w, h);
    endtask

    // wait for the block to go idle before touching the register
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_atlas(logic [gasp_pkg::DIM_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_atlas(value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int atlas, int count, bit calm, bit stall_output);
        int                         side;
        int                         r;
        logic [gasp_pkg::DIM_W-1:0] w;
        logic [gasp_pkg::DIM_W-1:0] h;
        settle();
        write_atlas(gasp_pkg::DIM_W'(atlas));
        side = (atlas > gasp_pkg::ATLAS_MAX) ? gasp_pkg::ATLAS_MAX : atlas;
        quiet = calm;
        if (stall_output)
            hold_req = 1'b1;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_item(1'b1, gasp_pkg::DIM_W'($urandom), gasp_pkg::DIM_W'($urandom));
            end else if (r < 8) begin
                w = gasp_pkg::DIM_W'($urandom);
                h = gasp_pkg::DIM_W'($urandom);
                if (r < 5)
                    w = '0;
                else if (r < 7)
                    h = '0;
                else begin
                    w = '0;
                    h = '0;
                end
                send_item(1'b0, w, h);
            end else begin
                w = pick_dim(side);
                h = pick_dim(side);
                send_item(1'b0, w, h);
            end
        end
        quiet = 1'b0;
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                gap = quiet ? 0 : $urandom_range(0, 14);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_placement(m_tuser, m_tdata);
        end
    end

    initial begin
        sb = new();
        sb.reset_state();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset atlas size, empty glyphs, edge sizes
        send_item(1'b1, 13'h1FFF, 13'h1FFF);
        send_item(1'b0, 13'd0, 13'd5);
        send_item(1'b0, 13'd7, 13'd0);
        send_item(1'b0, 13'd0, 13'd0);
        send_item(1'b0, 13'd1, 13'd1);
        send_item(1'b0, 13'd10, 13'd20);
        send_item(1'b0, 13'd1023, 13'd1);
        send_item(1'b0, 13'd1024, 13'd1);
        send_item(1'b0, 13'd1, 13'd1023);
        send_item(1'b0, 13'd4096, 13'd4096);
        send_item(1'b0, 13'h1FFF, 13'h1FFF);
        send_item(1'b0, 13'd1023, 13'd1023);
        send_item(1'b1, 13'd0, 13'd0);

        // smallest atlas: run into the page limit
        settle();
        write_atlas(13'd16);
        for (int i = 0; i < gasp_pkg::MAX_PAGES + 1; i++)
            send_item(1'b0, 13'd15, 13'd15);
        send_item(1'b0, 13'd16, 13'd1);
        send_item(1'b1, 13'd0, 13'd0);
        send_item(1'b0, 13'd16, 13'd1);
        send_item(1'b0, 13'd3, 13'd3);

        run_phase(16, 80, 1'b0, 1'b0);
        run_phase(4096, 80, 1'b0, 1'b1);
        run_phase(8191, 80, 1'b1, 1'b0);
        run_phase(17, 80, 1'b0, 1'b0);
        run_phase($urandom_range(16, 4096), 100, 1'b0, 1'b0);
        run_phase(64, 100, 1'b0, 1'b1);
        run_phase($urandom_range(16, 256), 100, 1'b1, 1'b0);
        run_phase(1024, 80, 1'b0, 1'b0);

        settle();
        if (sb.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
